// ===== hdl/smsl_pkg.sv =====
package smsl_pkg;

	// data word widths
	localparam int DW = 48;           // clamped intermediate, signed
	localparam int MW = 47;           // magnitude of a clamped intermediate
	localparam int HW = 24;           // multiplier half width
	localparam int AW = 2 * DW - 2;   // multiply accumulator (94 bits)
	localparam int CW = 34;           // CORDIC x, y, z (Q2.30 plus guard)
	localparam int QW = 64;           // divider dividend / quotient
	localparam int TW = 18;           // heading angle
	localparam int RW = 36;           // angle derivative product

	typedef logic signed [DW-1:0] data_t;

	localparam data_t WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [TW-1:0] ANGLE_LIMIT = 18'sd102943;

	// Q16.16 constants
	localparam data_t C_ONE   = 48'sd65536;
	localparam data_t C_ALPHA = 48'sd6332287;
	localparam data_t C_BETA1 = 48'sd16510;
	localparam data_t C_BETA2 = 48'sd1403;
	localparam data_t C_MB    = 48'sd2310;
	localparam data_t C_B     = 48'sd1966;
	localparam data_t C_L     = 48'sd4456;
	localparam data_t C_GAIN  = 48'sd15378409;

	// CORDIC
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_N = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam logic [29:0] ATAN_TABLE [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0};

	localparam int DIV_STEPS = 64;
	localparam int MUL_PARTS = 4;

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_SWITCH_GAIN  = 1'd0;
	localparam cfg_idx_t REG_RATE_INVERSE = 1'd1;

	// operand sources
	typedef enum logic [4:0] {
		SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4,
		SRC_V, SRC_W, SRC_D, SRC_DD, SRC_THD, SRC_T, SRC_KN,
		SRC_ONE, SRC_ALPHA, SRC_BETA1, SRC_BETA2, SRC_MB, SRC_B, SRC_L, SRC_GAIN
	} src_t;

	typedef enum logic [2:0] {DST_R0, DST_R1, DST_R2, DST_R3, DST_R4} dst_t;

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		src_t     a;
		src_t     b;
		dst_t     dst;
	} prog_op_t;

	// steering law program: R0 num, R1 den, R2 den*G at the end
	localparam int PROG_LEN = 27;
	localparam prog_op_t PROGRAM [PROG_LEN] = '{
		'{OP_MUL, SRC_W,     SRC_T,     DST_R0},
		'{OP_ADD, SRC_ONE,   SRC_R0,    DST_R0},
		'{OP_MUL, SRC_R0,    SRC_DD,    DST_R0},
		'{OP_MUL, SRC_D,     SRC_T,     DST_R1},
		'{OP_SUB, SRC_R1,    SRC_L,     DST_R1},
		'{OP_MUL, SRC_MB,    SRC_W,     DST_R2},
		'{OP_MUL, SRC_R2,    SRC_V,     DST_R2},
		'{OP_MUL, SRC_BETA2, SRC_W,     DST_R3},
		'{OP_SUB, SRC_R2,    SRC_R3,    DST_R2},
		'{OP_MUL, SRC_R1,    SRC_R2,    DST_R2},
		'{OP_MUL, SRC_ALPHA, SRC_R2,    DST_R2},
		'{OP_ADD, SRC_R0,    SRC_R2,    DST_R0},
		'{OP_MUL, SRC_T,     SRC_T,     DST_R2},
		'{OP_ADD, SRC_ONE,   SRC_R2,    DST_R2},
		'{OP_MUL, SRC_W,     SRC_D,     DST_R3},
		'{OP_SUB, SRC_V,     SRC_R3,    DST_R3},
		'{OP_MUL, SRC_THD,   SRC_R3,    DST_R3},
		'{OP_MUL, SRC_R2,    SRC_R3,    DST_R2},
		'{OP_MUL, SRC_BETA1, SRC_V,     DST_R3},
		'{OP_MUL, SRC_W,     SRC_W,     DST_R4},
		'{OP_MUL, SRC_B,     SRC_R4,    DST_R4},
		'{OP_ADD, SRC_R3,    SRC_R4,    DST_R3},
		'{OP_MUL, SRC_T,     SRC_R3,    DST_R3},
		'{OP_SUB, SRC_R2,    SRC_R3,    DST_R2},
		'{OP_SUB, SRC_R0,    SRC_R2,    DST_R0},
		'{OP_SUB, SRC_KN,    SRC_R0,    DST_R0},
		'{OP_MUL, SRC_R1,    SRC_GAIN,  DST_R2}};

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE, CMD_CAPTURE, CMD_INIT, CMD_CORDIC, CMD_DIV_LOAD_TAN, CMD_DIV_STEP,
		CMD_TAN_SET, CMD_ALU, CMD_MUL_LATCH, CMD_MUL_PART, CMD_MUL_WB,
		CMD_DIV_LOAD_FIN, CMD_FINISH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [5:0] cnt;
		prog_op_t   op;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_CORDIC, ST_TDIV_LOAD, ST_TDIV, ST_TAN, ST_OP, ST_MUL,
		ST_MUL_WB, ST_FDIV_LOAD, ST_FDIV, ST_FIN
	} state_t;

endpackage

// ===== hdl/smsl_ctrl.sv =====
module smsl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  smsl_pkg::status_t status,
	output smsl_pkg::cmd_t   cmd
);
	import smsl_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [4:0] pc_q, pc_d;
	prog_op_t   op;

	assign op = PROGRAM[pc_q];

	// state, step counter and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pc_q    <= pc_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pc_d     = pc_q;
		in_ready = 1'b0;
		cmd.kind = CMD_NONE;
		cmd.cnt  = cnt_q;
		cmd.op   = op;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.kind = CMD_CAPTURE;
					state_d  = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.kind = CMD_INIT;
				cnt_d    = '0;
				state_d  = ST_CORDIC;
			end
			ST_CORDIC: begin
				cmd.kind = CMD_CORDIC;
				cnt_d    = cnt_q + 6'd1;
				if (cnt_q == 6'(CORDIC_N - 1)) state_d = ST_TDIV_LOAD;
			end
			ST_TDIV_LOAD: begin
				cmd.kind = CMD_DIV_LOAD_TAN;
				cnt_d    = '0;
				state_d  = ST_TDIV;
			end
			ST_TDIV: begin
				cmd.kind = CMD_DIV_STEP;
				cnt_d    = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_TAN;
			end
			ST_TAN: begin
				cmd.kind = CMD_TAN_SET;
				pc_d     = '0;
				state_d  = ST_OP;
			end
			ST_OP: begin
				if (op.kind == OP_MUL) begin
					cmd.kind = CMD_MUL_LATCH;
					cnt_d    = '0;
					state_d  = ST_MUL;
				end else begin
					cmd.kind = CMD_ALU;
					pc_d     = pc_q + 5'd1;
					if (pc_q == 5'(PROG_LEN - 1)) state_d = ST_FDIV_LOAD;
				end
			end
			ST_MUL: begin
				cmd.kind = CMD_MUL_PART;
				cnt_d    = cnt_q + 6'd1;
				if (cnt_q == 6'(MUL_PARTS - 1)) state_d = ST_MUL_WB;
			end
			ST_MUL_WB: begin
				cmd.kind = CMD_MUL_WB;
				pc_d     = pc_q + 5'd1;
				state_d  = (pc_q == 5'(PROG_LEN - 1)) ? ST_FDIV_LOAD : ST_OP;
			end
			ST_FDIV_LOAD: begin
				cmd.kind = CMD_DIV_LOAD_FIN;
				cnt_d    = '0;
				state_d  = ST_FDIV;
			end
			ST_FDIV: begin
				cmd.kind = CMD_DIV_STEP;
				cnt_d    = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (!status.out_busy) begin
					cmd.kind = CMD_FINISH;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/smsl_datapath.sv =====
module smsl_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smsl_pkg::cmd_t          cmd,
	output smsl_pkg::status_t       status,
	input  logic [23:0]             switch_gain,
	input  logic [15:0]             rate_inverse,
	input  logic signed [31:0]      surface,
	input  logic signed [31:0]      forward_speed,
	input  logic signed [31:0]      yaw_rate,
	input  logic signed [31:0]      lateral_distance,
	input  logic signed [31:0]      lateral_rate,
	input  logic signed [17:0]      heading_angle,
	output logic signed [31:0]      steer_effort,
	output logic                    divisor_zero,
	output logic                    out_valid,
	input  logic                    out_ready
);
	import smsl_pkg::*;

	// sample word
	logic signed [31:0]   s_q, v_q, w_q, d_q, dd_q;
	logic signed [TW-1:0] th_q, prev_q;
	logic signed [RW-1:0] thd_q;
	data_t                t_q;
	data_t                rf_q [5];

	// CORDIC
	logic signed [CW-1:0] x_q, y_q, z_q;

	// multiplier
	logic [MW-1:0] ma_q, mb_q;
	logic          mneg_q;
	logic [AW-1:0] acc_q;

	// divider
	logic [QW-1:0] dvd_q;
	logic [DW-1:0] rem_q, dv_q;

	// output register
	logic signed [31:0] res_q;
	logic               zero_q, out_valid_q;

	function automatic data_t clamp49(input logic signed [DW:0] v);
		if (v > (DW+1)'(WIDE_MAX)) return WIDE_MAX;
		if (v < -((DW+1)'(WIDE_MAX))) return -WIDE_MAX;
		return v[DW-1:0];
	endfunction

	function automatic logic [MW-1:0] mag(input data_t v);
		data_t a;
		a = (v < 0) ? -v : v;
		return a[MW-1:0];
	endfunction

	// heading clamp and angle difference
	logic signed [TW-1:0] th_clamp;
	logic signed [TW:0]   th_diff;
	logic signed [RW-1:0] thd_prod;
	logic [TW-2:0]        th_mag;

	always_comb begin
		if (heading_angle > ANGLE_LIMIT) th_clamp = ANGLE_LIMIT;
		else if (heading_angle < -ANGLE_LIMIT) th_clamp = -ANGLE_LIMIT;
		else th_clamp = heading_angle;
	end

	assign th_diff  = {th_q[TW-1], th_q} - {prev_q[TW-1], prev_q};
	assign thd_prod = th_diff * $signed({1'b0, rate_inverse});
	assign th_mag   = th_q[TW-1] ? (TW-1)'(-th_q) : th_q[TW-2:0];

	// sign-dependent switching term
	data_t kn;
	always_comb begin
		if (s_q > 0) kn = -$signed({24'd0, switch_gain});
		else if (s_q < 0) kn = $signed({24'd0, switch_gain});
		else kn = '0;
	end

	// operand selection
	function automatic data_t pick(input src_t sel);
		unique case (sel)
			SRC_R0:    return rf_q[0];
			SRC_R1:    return rf_q[1];
			SRC_R2:    return rf_q[2];
			SRC_R3:    return rf_q[3];
			SRC_R4:    return rf_q[4];
			SRC_V:     return DW'(v_q);
			SRC_W:     return DW'(w_q);
			SRC_D:     return DW'(d_q);
			SRC_DD:    return DW'(dd_q);
			SRC_THD:   return DW'(thd_q);
			SRC_T:     return t_q;
			SRC_KN:    return kn;
			SRC_ONE:   return C_ONE;
			SRC_ALPHA: return C_ALPHA;
			SRC_BETA1: return C_BETA1;
			SRC_BETA2: return C_BETA2;
			SRC_MB:    return C_MB;
			SRC_B:     return C_B;
			SRC_L:     return C_L;
			SRC_GAIN:  return C_GAIN;
			default:   return '0;
		endcase
	endfunction

	data_t opa, opb, alu_res;
	assign opa = pick(cmd.op.a);
	assign opb = pick(cmd.op.b);

	// saturating add / subtract
	always_comb begin
		if (cmd.op.kind == OP_SUB)
			alu_res = clamp49({opa[DW-1], opa} - {opb[DW-1], opb});
		else
			alu_res = clamp49({opa[DW-1], opa} + {opb[DW-1], opb});
	end

	// one 24x24 partial product per cycle
	logic [HW-1:0]   ph_a, ph_b;
	logic [2*HW-1:0] pp;
	logic [AW-1:0]   pp_sh;

	assign ph_a = cmd.cnt[0] ? {1'b0, ma_q[MW-1:HW]} : ma_q[HW-1:0];
	assign ph_b = cmd.cnt[1] ? {1'b0, mb_q[MW-1:HW]} : mb_q[HW-1:0];
	assign pp   = ph_a * ph_b;

	always_comb begin
		unique case (cmd.cnt[1:0])
			2'd0:    pp_sh = AW'(pp);
			2'd3:    pp_sh = AW'(pp) << (2 * HW);
			default: pp_sh = AW'(pp) << HW;
		endcase
	end

	// truncated, saturated product
	logic [MW-1:0] mul_mag;
	data_t         mul_res;
	assign mul_mag = (|acc_q[AW-1:MW+16]) ? WIDE_MAX[MW-1:0] : acc_q[MW+15:16];
	assign mul_res = mneg_q ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});

	// CORDIC step
	logic signed [CW-1:0] cdx, cdy, cat;
	assign cdx = y_q >>> cmd.cnt[4:0];
	assign cdy = x_q >>> cmd.cnt[4:0];
	assign cat = $signed({{(CW-30){1'b0}}, ATAN_TABLE[cmd.cnt[4:0]]});

	// restoring divider step
	logic [DW:0] div_sh, div_diff;
	assign div_sh   = {rem_q, dvd_q[QW-1]};
	assign div_diff = div_sh - {1'b0, dv_q};

	// tangent from the quotient
	logic [MW-1:0]       tq;
	logic [31:0]         y_mag;
	assign tq    = (x_q <= 0 || |dvd_q[QW-1:MW]) ? WIDE_MAX[MW-1:0] : dvd_q[MW-1:0];
	assign y_mag = y_q[CW-1] ? 32'(-y_q) : 32'(y_q);

	// final quotient and saturation
	logic [DW-1:0]      dg_mag;
	logic               q_neg;
	logic signed [31:0] fin_res;
	assign dg_mag = (rf_q[2] == 0) ? DW'(1) : DW'(mag(rf_q[2]));
	assign q_neg  = rf_q[0][DW-1] != rf_q[1][DW-1];

	always_comb begin
		if (q_neg) begin
			if (dvd_q > QW'(64'h8000_0000)) fin_res = 32'sh8000_0000;
			else fin_res = -$signed(dvd_q[31:0]);
		end else begin
			if (dvd_q > QW'(64'h7FFF_FFFF)) fin_res = 32'sh7FFF_FFFF;
			else fin_res = $signed(dvd_q[31:0]);
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			CMD_CAPTURE: begin
				s_q  <= surface;
				v_q  <= forward_speed;
				w_q  <= yaw_rate;
				d_q  <= lateral_distance;
				dd_q <= lateral_rate;
				th_q <= th_clamp;
			end
			CMD_INIT: begin
				thd_q <= thd_prod;
				x_q   <= CW'(1) << 30;
				y_q   <= '0;
				z_q   <= CW'(th_mag) << 14;
			end
			CMD_CORDIC: begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - cdx;
					y_q <= y_q + cdy;
					z_q <= z_q - cat;
				end else begin
					x_q <= x_q + cdx;
					y_q <= y_q - cdy;
					z_q <= z_q + cat;
				end
			end
			CMD_DIV_LOAD_TAN: begin
				dvd_q <= QW'({y_mag, 16'd0});
				dv_q  <= DW'($unsigned(x_q));
				rem_q <= '0;
			end
			CMD_DIV_STEP: begin
				if (!div_diff[DW]) begin
					rem_q <= div_diff[DW-1:0];
					dvd_q <= {dvd_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[DW-1:0];
					dvd_q <= {dvd_q[QW-2:0], 1'b0};
				end
			end
			CMD_TAN_SET: begin
				t_q <= (y_q[CW-1] != th_q[TW-1]) ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
			end
			CMD_ALU: rf_q[cmd.op.dst] <= alu_res;
			CMD_MUL_LATCH: begin
				ma_q   <= mag(opa);
				mb_q   <= mag(opb);
				mneg_q <= opa[DW-1] != opb[DW-1];
			end
			CMD_MUL_PART: begin
				if (cmd.cnt[1:0] == 2'd0) acc_q <= pp_sh;
				else acc_q <= acc_q + pp_sh;
			end
			CMD_MUL_WB: rf_q[cmd.op.dst] <= mul_res;
			CMD_DIV_LOAD_FIN: begin
				dvd_q <= {1'b0, mag(rf_q[0]), 16'd0};
				dv_q  <= dg_mag;
				rem_q <= '0;
			end
			CMD_FINISH: begin
				if (rf_q[1] == 0) begin
					res_q  <= rf_q[0][DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					zero_q <= 1'b1;
				end else begin
					res_q  <= fin_res;
					zero_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// stored angle and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.kind == CMD_INIT) prev_q <= th_q;
			if (cmd.kind == CMD_FINISH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign steer_effort    = res_q;
	assign divisor_zero    = zero_q;
	assign out_valid       = out_valid_q;

endmodule

// ===== hdl/sliding_mode_steering_law.sv =====
// Sliding-mode steering law: one word in gives one word out, steer_effort (Q16.16,
// saturated) and divisor_zero. Items are handled one at a time; each item runs the
// 64-step restoring divider twice (tangent and final quotient), the CORDIC
// iterations and 17 products through a shared 24x24 multiplier.
// A new word is taken as soon as the previous one has reached the output
// register. Config writes (0: switch_gain, 1: rate_inverse) apply while idle: the
// user must keep to this, as the block itself does not enforce it.
module sliding_mode_steering_law (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  smsl_pkg::cfg_idx_t cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] surface,
	input  logic signed [31:0] forward_speed,
	input  logic signed [31:0] yaw_rate,
	input  logic signed [31:0] lateral_distance,
	input  logic signed [31:0] lateral_rate,
	input  logic signed [17:0] heading_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] steer_effort,
	output logic               divisor_zero
);
	import smsl_pkg::*;

	logic [23:0] switch_gain_q;
	logic [15:0] rate_inverse_q;
	cmd_t        cmd;
	status_t     status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_gain_q  <= 24'd2949120;
			rate_inverse_q <= 16'd10000;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SWITCH_GAIN:  switch_gain_q  <= cfg_data;
				REG_RATE_INVERSE: rate_inverse_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	smsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	smsl_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.switch_gain      (switch_gain_q),
		.rate_inverse     (rate_inverse_q),
		.surface          (surface),
		.forward_speed    (forward_speed),
		.yaw_rate         (yaw_rate),
		.lateral_distance (lateral_distance),
		.lateral_rate     (lateral_rate),
		.heading_angle    (heading_angle),
		.steer_effort     (steer_effort),
		.divisor_zero     (divisor_zero),
		.out_valid        (out_valid),
		.out_ready        (out_ready)
	);

endmodule
